/* rtl/siaf_pkg.sv */
// Package: shared constants, types and codes of the symmetry image atom finder.
`default_nettype none

package siaf_pkg;

    // Table size and fixed-point format
    localparam int ATOMS      = 256;
    localparam int FRAC_BITS  = 24;

    // Field widths
    localparam int COORD_W    = 28;
    localparam int FUNC_W     = 2;
    localparam int AIDX_W     = 8;
    localparam int ROT_W      = 18;
    localparam int CNT_REG_W  = 9;
    localparam int TOL_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    // Derived widths
    localparam int IDX_W      = (ATOMS > 1) ? $clog2(ATOMS) : 1;
    localparam int CNT_W      = $clog2(ATOMS + 1);
    localparam int ARITH_W    = FRAC_BITS;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16777);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ARITH_W-1:0] t_arith;
    typedef logic [IDX_W-1:0]          t_addr;
    typedef logic [CNT_W-1:0]          t_cnt;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_pos;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD = 2'd0,
        FN_OP   = 2'd1,
        FN_ROT  = 2'd2,
        FN_NONE = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATOM_COUNT = 1'b0,
        CFG_TOLERANCE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RD_ATOM,
        RD_CENTER,
        RD_FIRST,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ATOM,
        S_CENTER,
        S_IMAGE,
        S_SWEEP,
        S_DONE
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic    load;
        logic    capture;
        t_rd_sel rd_sel;
        logic    latch_p;
        logic    form_image;
        logic    sweep_clr;
        logic    sweep_step;
        logic    set_hit;
        logic    set_miss;
        logic    out_load;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        t_func req_func;
        logic  in_range;
        logic  hit;
        logic  last;
        logic  out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/siaf_in_if.sv */
// Interface: request channel (load or query) with valid/ready handshake.
`default_nettype none

interface siaf_in_if import siaf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [AIDX_W-1:0]    atom_index;
    logic [AIDX_W-1:0]    center_index;
    logic [ROT_W-1:0]     rotation;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;

    modport source (
        output valid, func, atom_index, center_index, rotation, coord_x, coord_y, coord_z,
        input  ready
    );
    modport sink (
        input  valid, func, atom_index, center_index, rotation, coord_x, coord_y, coord_z,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/siaf_out_if.sv */
// Interface: result channel with valid/ready handshake.
`default_nettype none

interface siaf_out_if import siaf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [AIDX_W-1:0] image_index;

    modport source (
        output valid, found, image_index,
        input  ready
    );
    modport sink (
        input  valid, found, image_index,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/symmetry_image_atom_finder_core.sv */
// Top level: symmetry image atom finder, controller plus datapath.
// Sequence: a load is written at accept; a query whose atom index is out of range goes from
//   the atom state straight to the result hand-off, else through center read, image and sweep.
// Occupancy: one request at a time; a query holds the block through the sweep, which tests
//   one entry per cycle, and while an earlier result still waits in the output register.
// Reset (sync, active low): idle, atom_count 0, tolerance 16777; position table undefined.
`default_nettype none

module symmetry_image_atom_finder_core import siaf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // request and result channels
    siaf_in_if.sink                    i_req,
    siaf_out_if.source                 o_rsp
);

    t_cmd cmd;
    t_sts sts;
    logic req_ready;

    // sequencer: accepts a request only when idle, steps through
    // atom read, center read, image, sweep, and result hand-off
    siaf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    assign i_req.ready = req_ready;

    // storage and arithmetic; result sits in an output register so the
    // sweep state machine is released once the result is loaded
    siaf_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_req.func),
        .i_atom_index   (i_req.atom_index),
        .i_center_index (i_req.center_index),
        .i_rotation     (i_req.rotation),
        .i_coord_x      (i_req.coord_x),
        .i_coord_y      (i_req.coord_y),
        .i_coord_z      (i_req.coord_z),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready),
        .o_found        (o_rsp.found),
        .o_image_index  (o_rsp.image_index),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule

`default_nettype wire

/* rtl/siaf_ctrl.sv */
// Controller: sequences position reads, image formation and the table sweep.
`default_nettype none

module siaf_ctrl import siaf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   is_query;

    assign is_query = (i_sts.req_func == FN_OP) || (i_sts.req_func == FN_ROT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && is_query) n_state = S_ATOM;
            end
            S_ATOM: begin
                n_state = i_sts.in_range ? S_CENTER : S_DONE;
            end
            S_CENTER: n_state = S_IMAGE;
            S_IMAGE:  n_state = S_SWEEP;
            S_SWEEP: begin
                if (i_sts.hit || i_sts.last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load    = (i_sts.req_func == FN_LOAD);
                    o_cmd.capture = is_query;
                end
            end
            S_ATOM: begin
                if (i_sts.in_range) begin
                    o_cmd.rd_sel = RD_ATOM;
                end else begin
                    o_cmd.set_miss = 1'b1;
                end
            end
            S_CENTER: begin
                o_cmd.rd_sel  = RD_CENTER;
                o_cmd.latch_p = 1'b1;
            end
            S_IMAGE: begin
                o_cmd.form_image = 1'b1;
                o_cmd.rd_sel     = RD_FIRST;
                o_cmd.sweep_clr  = 1'b1;
            end
            S_SWEEP: begin
                if (i_sts.hit) begin
                    o_cmd.set_hit = 1'b1;
                end else if (i_sts.last) begin
                    o_cmd.set_miss = 1'b1;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                    o_cmd.rd_sel     = RD_NEXT;
                end
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/siaf_datapath.sv */
// Datapath: config registers, position memory, image arithmetic, match test, result register.
`default_nettype none

module siaf_datapath import siaf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // request payload
    input  wire logic [FUNC_W-1:0]     i_func,
    input  wire logic [AIDX_W-1:0]     i_atom_index,
    input  wire logic [AIDX_W-1:0]     i_center_index,
    input  wire logic [ROT_W-1:0]      i_rotation,
    input  wire t_coord                i_coord_x,
    input  wire t_coord                i_coord_y,
    input  wire t_coord                i_coord_z,
    // result
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_found,
    output logic [AIDX_W-1:0]          o_image_index,
    // control
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts
);

    localparam int CMP_W = (FRAC_BITS + 1 > TOL_W) ? FRAC_BITS + 1 : TOL_W;

    // config registers
    logic [CNT_REG_W-1:0] r_atom_count;
    logic [TOL_W-1:0]     r_tolerance;

    // captured request
    t_func             r_func;
    logic [AIDX_W-1:0] r_ai;
    logic [AIDX_W-1:0] r_ci;
    logic [ROT_W-1:0]  r_rot;
    t_coord            r_t [3];

    // memory and working registers
    t_pos   r_mem [ATOMS];
    t_pos   r_rd;
    t_pos   r_p;
    logic   r_c_ok;
    t_arith r_img [3];
    t_arith n_img [3];
    t_cnt   r_sweep;
    t_addr  rd_addr;
    t_cnt   limit;

    logic              r_found;
    logic [AIDX_W-1:0] r_res_idx;
    logic              r_out_valid;
    logic              r_out_found;
    logic [AIDX_W-1:0] r_out_idx;

    // entry is -2..1 (two's complement)
    function automatic t_arith rot_term(input logic [1:0] e, input t_arith v);
        t_arith res;
        case (e)
            2'b00:   res = '0;
            2'b01:   res = v;
            2'b10:   res = -(v <<< 1);
            2'b11:   res = -v;
            default: res = '0;
        endcase
        return res;
    endfunction

    // distance of (a - b) to the nearest integer below tolerance
    function automatic logic near_int(input t_arith a, input t_arith b,
                                      input logic [TOL_W-1:0] tol);
        logic [FRAC_BITS-1:0] f;
        logic [FRAC_BITS:0]   far;
        logic [FRAC_BITS:0]   d;
        f   = a - b;
        far = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, f};
        d   = ({1'b0, f} < far) ? {1'b0, f} : far;
        return CMP_W'(d) < CMP_W'(tol);
    endfunction

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atom_count <= '0;
            r_tolerance  <= TOL_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ATOM_COUNT: r_atom_count <= CNT_REG_W'(i_cfg_data);
                CFG_TOLERANCE:  r_tolerance  <= TOL_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign limit = (32'(r_atom_count) < ATOMS) ? CNT_W'(r_atom_count) : CNT_W'(ATOMS);

    // read address select
    always_comb begin
        case (i_cmd.rd_sel)
            RD_ATOM:   rd_addr = t_addr'(r_ai);
            RD_CENTER: rd_addr = t_addr'(r_ci);
            RD_FIRST:  rd_addr = '0;
            RD_NEXT:   rd_addr = t_addr'(r_sweep + 1'b1);
            default:   rd_addr = '0;
        endcase
    end

    // position memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (32'(i_atom_index) < ATOMS)) begin
            r_mem[t_addr'(i_atom_index)] <= '{x: i_coord_x, y: i_coord_y, z: i_coord_z};
        end
        r_rd <= r_mem[rd_addr];
    end

    // image = R*rel + c
    always_comb begin
        t_arith p   [3];
        t_arith c   [3];
        t_arith rel [3];
        t_arith acc;
        p[0] = t_arith'(r_p.x);
        p[1] = t_arith'(r_p.y);
        p[2] = t_arith'(r_p.z);
        if (r_func == FN_ROT) begin
            c[0] = r_c_ok ? t_arith'(r_rd.x) : '0;
            c[1] = r_c_ok ? t_arith'(r_rd.y) : '0;
            c[2] = r_c_ok ? t_arith'(r_rd.z) : '0;
        end else begin
            c[0] = t_arith'(r_t[0]);
            c[1] = t_arith'(r_t[1]);
            c[2] = t_arith'(r_t[2]);
        end
        for (int k = 0; k < 3; k++) begin
            rel[k] = (r_func == FN_ROT) ? p[k] - c[k] : p[k];
        end
        for (int r = 0; r < 3; r++) begin
            acc = c[r];
            for (int k = 0; k < 3; k++) begin
                acc = acc + rot_term(r_rot[2*(3*r+k) +: 2], rel[k]);
            end
            n_img[r] = acc;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= t_func'(i_func);
            r_ai   <= i_atom_index;
            r_ci   <= i_center_index;
            r_rot  <= i_rotation;
            r_t[0] <= i_coord_x;
            r_t[1] <= i_coord_y;
            r_t[2] <= i_coord_z;
            r_c_ok <= (32'(i_center_index) < ATOMS);
        end
        if (i_cmd.latch_p) begin
            r_p <= r_rd;
        end
        if (i_cmd.form_image) begin
            r_img <= n_img;
        end
        if (i_cmd.sweep_clr) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_step) begin
            r_sweep <= r_sweep + 1'b1;
        end
        if (i_cmd.set_hit) begin
            r_found   <= 1'b1;
            r_res_idx <= AIDX_W'(r_sweep);
        end else if (i_cmd.set_miss) begin
            r_found   <= 1'b0;
            r_res_idx <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_found;
            r_out_idx   <= r_res_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // status
    assign o_sts.req_func = t_func'(i_func);
    assign o_sts.in_range = 32'(r_ai) < 32'(limit);
    assign o_sts.hit      = near_int(t_arith'(r_rd.x), r_img[0], r_tolerance)
                          && near_int(t_arith'(r_rd.y), r_img[1], r_tolerance)
                          && near_int(t_arith'(r_rd.z), r_img[2], r_tolerance);
    assign o_sts.last     = (CNT_W'(r_sweep + 1'b1) >= limit);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_image_index = r_out_idx;

endmodule

`default_nettype wire

/* verif/siaf_match_checker.sv */
// Checker: mirrors the position table, predicts each query's match and compares results.
`default_nettype none

module siaf_match_checker import siaf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    siaf_in_if                         i_req_mon,
    siaf_out_if                        i_rsp_mon,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        logic              found;
        logic [AIDX_W-1:0] image_index;
    } t_match;

    longint               pos_tab [ATOMS][3];
    logic [CNT_REG_W-1:0] atom_count;
    logic [TOL_W-1:0]     tolerance;
    t_match               match_q [$];
    int                   fail_count = 0;

    // distance of the fraction part to the nearest integer, strictly below tolerance
    function automatic bit near_lattice(longint diff);
        longint unit, frac, span;
        unit = longint'(1) << FRAC_BITS;
        frac = diff & (unit - 1);
        span = unit - frac;
        if (frac < span) span = frac;
        return span < longint'(tolerance);
    endfunction

    function automatic t_match find_image(t_func fn, int atom, int center,
                                          logic [ROT_W-1:0] rot,
                                          longint tx, longint ty, longint tz);
        longint            base [3];
        longint            rel [3];
        longint            img [3];
        longint            trans [3];
        logic signed [1:0] coef;
        int                limit;
        t_match            res;
        res   = '0;
        trans = '{tx, ty, tz};
        limit = (int'(atom_count) > ATOMS) ? ATOMS : int'(atom_count);
        if (atom >= limit) return res;
        for (int k = 0; k < 3; k++) begin
            if (fn == FN_ROT) begin
                base[k] = (center < ATOMS) ? pos_tab[center][k] : 0;
                rel[k]  = pos_tab[atom][k] - base[k];
            end else begin
                base[k] = trans[k];
                rel[k]  = pos_tab[atom][k];
            end
        end
        for (int r = 0; r < 3; r++) begin
            img[r] = base[r];
            for (int k = 0; k < 3; k++) begin
                coef   = rot[2*(3*r+k) +: 2];
                img[r] += longint'(coef) * rel[k];
            end
        end
        for (int i = 0; i < limit; i++) begin
            if (near_lattice(pos_tab[i][0] - img[0]) &&
                near_lattice(pos_tab[i][1] - img[1]) &&
                near_lattice(pos_tab[i][2] - img[2])) begin
                res.found       = 1'b1;
                res.image_index = AIDX_W'(i);
                return res;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_match got;
        t_match want;
        t_func  fn;
        if (!i_rst_n) begin
            atom_count = '0;
            tolerance  = TOL_RESET;
            match_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ATOM_COUNT) atom_count = i_cfg_data[CNT_REG_W-1:0];
                else tolerance = i_cfg_data[TOL_W-1:0];
            end
            // results first: a result never belongs to a request taken at the same edge
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got.found       = i_rsp_mon.found;
                got.image_index = i_rsp_mon.image_index;
                if (match_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none actual found %0b index %0d",
                             $time, got.found, got.image_index);
                    fail_count++;
                end else begin
                    want = match_q.pop_front();
                    if (got.found !== want.found) begin
                        $display("%0t: found mismatch: expected %0b actual %0b",
                                 $time, want.found, got.found);
                        fail_count++;
                    end
                    if (got.image_index !== want.image_index) begin
                        $display("%0t: image_index mismatch: expected %0d actual %0d",
                                 $time, want.image_index, got.image_index);
                        fail_count++;
                    end
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                fn = t_func'(i_req_mon.func);
                case (fn)
                    FN_LOAD: begin
                        pos_tab[i_req_mon.atom_index][0] = longint'(i_req_mon.coord_x);
                        pos_tab[i_req_mon.atom_index][1] = longint'(i_req_mon.coord_y);
                        pos_tab[i_req_mon.atom_index][2] = longint'(i_req_mon.coord_z);
                    end
                    FN_OP, FN_ROT: begin
                        match_q.push_back(find_image(fn, int'(i_req_mon.atom_index),
                                                     int'(i_req_mon.center_index),
                                                     i_req_mon.rotation,
                                                     longint'(i_req_mon.coord_x),
                                                     longint'(i_req_mon.coord_y),
                                                     longint'(i_req_mon.coord_z)));
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= match_q.size();
    end

endmodule

`default_nettype wire

/* verif/tb_symmetry_image_atom_finder_core.sv */
// Testbench top: drives loads, queries and config of the atom finder and gives the verdict.
`default_nettype none

module tb_symmetry_image_atom_finder_core;
    import siaf_pkg::*;

    localparam int     CLK_HALF    = 4;
    localparam int     CYCLE_LIMIT = 2_000_000;
    localparam int     PHASES      = 12;
    localparam int     PHASE_ITEMS = 100;
    localparam longint ONE         = longint'(1) << FRAC_BITS;
    localparam int     TOL_MAX     = 1 << (FRAC_BITS - 1);
    localparam longint COORD_MAX   = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_MIN   = -(longint'(1) << (COORD_W - 1));

    // rotation patterns: 2-bit entries, entry 0 in the low bits
    localparam logic [ROT_W-1:0] ROT_IDENT  = 18'h10101;
    localparam logic [ROT_W-1:0] ROT_ZERO   = 18'h00000;
    localparam logic [ROT_W-1:0] ROT_ALL_M2 = 18'h2AAAA;   // every entry is the -2 pattern
    localparam logic [ROT_W-1:0] ROT_ALL_M1 = 18'h3FFFF;
    localparam logic [ROT_W-1:0] ROT_ALL_P1 = 18'h15555;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  rsp_ready = 1'b0;
    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;

    // Stimulus-side copy of the loaded positions. It only serves to aim operation
    // queries at real atoms so that hits are frequent; the checker predicts on its own.
    longint tab [ATOMS][3];
    int     cur_count;
    int     cur_tol;
    int     burst_left = 0;
    int     stall_mode = 0;
    int     stall_run  = 0;

    siaf_in_if  req_if ();
    siaf_out_if rsp_if ();

    assign rsp_if.ready = rsp_ready;

    always #(CLK_HALF) clk = ~clk;

    symmetry_image_atom_finder_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    siaf_match_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_req_mon    (req_if),
        .i_rsp_mon    (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result-side backpressure. Each stretch picks a mode: always ready, coin flip,
    // mostly ready, or mostly stalled. Stretch lengths are random so stalls land on
    // every phase of a sweep, including the cycle the result first shows up.
    always @(posedge clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(4, 80);
        end else begin
            stall_run = stall_run - 1;
        end
        case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ready <= ($urandom_range(0, 7) != 0);
            default: rsp_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Watchdog: a hang or a lost result ends here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Fractional position on a quarter grid plus a little jitter, sometimes shifted
    // one cell down. Any integer rotation maps the grid onto itself, so rotation
    // queries find images in a table built from these.
    function automatic longint grid_coord();
        longint c;
        c = longint'($urandom_range(0, 3)) * (ONE / 4) + longint'($urandom_range(0, 64)) - 32;
        if ($urandom_range(0, 1) == 1) c = c - ONE;
        return c;
    endfunction

    // Full-width random coordinate, all 28 bits toggling
    function automatic longint wide_coord();
        return longint'(t_coord'($urandom()));
    endfunction

    // Either 18 random bits (any entry pattern, -2 included) or a signed permutation
    function automatic logic [ROT_W-1:0] random_rotation();
        int               perm [3];
        int               pick;
        int               swap;
        logic [ROT_W-1:0] rot;
        if ($urandom_range(0, 2) != 0) return ROT_W'($urandom());
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
            pick       = $urandom_range(0, i);
            swap       = perm[i];
            perm[i]    = perm[pick];
            perm[pick] = swap;
        end
        rot = '0;
        for (int r = 0; r < 3; r++) begin
            rot[2*(3*r+perm[r]) +: 2] = ($urandom_range(0, 1) == 1) ? 2'b11 : 2'b01;
        end
        return rot;
    endfunction

    // Mostly an atom inside the searched range, now and then any index (out of range
    // whenever the count is below the table size)
    function automatic int pick_atom();
        if (cur_count == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, ATOMS - 1);
        return $urandom_range(0, cur_count - 1);
    endfunction

    // Sender with bursts: a new burst may open with a random gap with valid low.
    // Valid stays high across back-to-back requests inside a burst.
    task automatic send_request(t_func fn, int atom, int center, logic [ROT_W-1:0] rot,
                                longint x, longint y, longint z);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        req_if.valid        <= 1'b1;
        req_if.func         <= fn;
        req_if.atom_index   <= AIDX_W'(atom);
        req_if.center_index <= AIDX_W'(center);
        req_if.rotation     <= rot;
        req_if.coord_x      <= COORD_W'(x);
        req_if.coord_y      <= COORD_W'(y);
        req_if.coord_z      <= COORD_W'(z);
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        if (fn == FN_LOAD) begin
            tab[atom][0] = longint'(t_coord'(x));
            tab[atom][1] = longint'(t_coord'(y));
            tab[atom][2] = longint'(t_coord'(z));
        end
    endtask

    task automatic load_atom(int idx, bit wide);
        if (wide) begin
            send_request(FN_LOAD, idx, $urandom_range(0, ATOMS - 1), ROT_W'($urandom()),
                         wide_coord(), wide_coord(), wide_coord());
        end else begin
            send_request(FN_LOAD, idx, $urandom_range(0, ATOMS - 1), ROT_W'($urandom()),
                         grid_coord(), grid_coord(), grid_coord());
        end
    endtask

    // Operation query whose translation lands R*p(src) on p(dst) plus a random lattice
    // shift, with the x coordinate off by noise. Truncation to 28 bits moves the
    // image by whole cells only, so the aim survives.
    task automatic send_aimed_op(int src, int dst, logic [ROT_W-1:0] rot, longint noise);
        longint            trans [3];
        logic signed [1:0] coef;
        for (int r = 0; r < 3; r++) begin
            trans[r] = tab[dst][r] + ONE * (longint'($urandom_range(0, 2)) - 1);
            for (int k = 0; k < 3; k++) begin
                coef     = rot[2*(3*r+k) +: 2];
                trans[r] = trans[r] - longint'(coef) * tab[src][k];
            end
        end
        trans[0] = trans[0] + noise;
        send_request(FN_OP, src, $urandom_range(0, ATOMS - 1), rot, trans[0], trans[1], trans[2]);
    endtask

    // Stop sending and wait until every outstanding query has answered, then a tail
    // for requests that give no result (loads, the unused function code).
    // Pending is a registered copy of the checker's queue size, hence the first edge.
    task automatic settle(int tail);
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // Both registers are written back to back, only with the block idle
    task automatic set_config(int count, int tol);
        settle(8);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ATOM_COUNT;
        cfg_data  <= CFG_DATA_W'(count);
        @(posedge clk);
        cfg_index <= CFG_TOLERANCE;
        cfg_data  <= CFG_DATA_W'(tol);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_count = count;
        cur_tol   = tol;
    endtask

    task automatic send_random_item();
        int     sel;
        longint noise;
        sel   = $urandom_range(0, 99);
        noise = longint'($urandom_range(0, cur_tol / 2));
        if ($urandom_range(0, 1) == 1) noise = -noise;
        if (sel < 10) begin
            load_atom($urandom_range(0, ATOMS - 1), $urandom_range(0, 4) == 0);
        end else if (sel < 14) begin
            send_request(FN_NONE, $urandom_range(0, ATOMS - 1), $urandom_range(0, ATOMS - 1),
                         ROT_W'($urandom()), wide_coord(), wide_coord(), wide_coord());
        end else if (sel < 40) begin
            send_aimed_op(pick_atom(), pick_atom(), random_rotation(), noise);
        end else if (sel < 55) begin
            if ($urandom_range(0, 1) == 1) begin
                send_request(FN_OP, pick_atom(), $urandom_range(0, ATOMS - 1), random_rotation(),
                             grid_coord(), grid_coord(), grid_coord());
            end else begin
                send_request(FN_OP, pick_atom(), $urandom_range(0, ATOMS - 1), random_rotation(),
                             wide_coord(), wide_coord(), wide_coord());
            end
        end else begin
            // coordinates are unused by a rotation query; random anyway
            send_request(FN_ROT, pick_atom(), $urandom_range(0, ATOMS - 1), random_rotation(),
                         wide_coord(), wide_coord(), wide_coord());
        end
    endtask

    initial begin
        int count_sel;
        int tol_sel;
        int next_count;
        int next_tol;
        req_if.valid        = 1'b0;
        req_if.func         = FN_LOAD;
        req_if.atom_index   = '0;
        req_if.center_index = '0;
        req_if.rotation     = '0;
        req_if.coord_x      = '0;
        req_if.coord_y      = '0;
        req_if.coord_z      = '0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_ATOM_COUNT;
        cfg_data            = '0;
        cur_count           = 0;
        cur_tol             = int'(TOL_RESET);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: the count is zero, so any query misses without touching the table.
        send_request(FN_OP, 0, 0, ROT_IDENT, 0, 0, 0);
        send_request(FN_ROT, ATOMS - 1, ATOMS - 1, ROT_ALL_M2, COORD_MAX, COORD_MIN, 0);
        send_request(FN_NONE, 0, 0, ROT_ZERO, 0, 0, 0);

        // Fill the whole table before anything searches it
        for (int i = 0; i < ATOMS; i++) load_atom(i, 1'b0);
        set_config(ATOMS, int'(TOL_RESET));

        // Directed: rotation extremes, both query kinds, table ends
        send_aimed_op(5, 5, ROT_IDENT, 0);
        send_request(FN_OP, 77, 0, ROT_ZERO, tab[77][0], tab[77][1], tab[77][2]);
        send_aimed_op(0, ATOMS - 1, ROT_ALL_M2, 0);
        send_aimed_op(ATOMS - 1, 0, ROT_ALL_M1, 0);
        send_aimed_op(128, 64, ROT_ALL_P1, 0);
        send_request(FN_ROT, 9, 9, random_rotation(), 0, 0, 0);   // atom on its center
        send_request(FN_ROT, ATOMS - 1, 0, ROT_ALL_M2, 0, 0, 0);
        send_request(FN_ROT, 0, ATOMS - 1, ROT_ALL_P1, 0, 0, 0);
        send_request(FN_OP, 3, 0, ROT_ALL_M1, COORD_MAX, COORD_MAX, COORD_MAX);
        send_request(FN_OP, 3, 0, ROT_IDENT, COORD_MIN, COORD_MIN, COORD_MIN);
        send_request(FN_NONE, ATOMS - 1, ATOMS - 1, '1, COORD_MAX, COORD_MAX, COORD_MAX);
        // extreme stored position, then aim at it
        send_request(FN_LOAD, 200, 0, ROT_ZERO, COORD_MAX, COORD_MIN, 0);
        send_aimed_op(200, 200, ROT_IDENT, 0);
        // tolerance edge: one below still matches, exactly at tolerance does not
        send_aimed_op(10, 20, ROT_IDENT, longint'(cur_tol) - 1);
        send_aimed_op(10, 20, ROT_IDENT, -longint'(cur_tol));

        // single searched atom, widest tolerance
        set_config(1, TOL_MAX);
        send_request(FN_OP, 0, 0, random_rotation(), wide_coord(), wide_coord(), wide_coord());
        send_request(FN_ROT, 1, 0, random_rotation(), 0, 0, 0);   // just past the count
        send_request(FN_OP, ATOMS - 1, 0, ROT_IDENT, 0, 0, 0);

        // zero tolerance: nothing can match
        set_config(ATOMS, 0);
        send_aimed_op(7, 7, ROT_IDENT, 0);
        send_request(FN_ROT, 40, 41, random_rotation(), 0, 0, 0);

        // Random phases, each with its own count and tolerance
        for (int ph = 0; ph < PHASES; ph++) begin
            count_sel = $urandom_range(0, 15);
            if (count_sel == 0) next_count = 0;
            else if (count_sel < 3) next_count = ATOMS;
            else if (count_sel < 6) next_count = $urandom_range(1, 8);
            else next_count = $urandom_range(9, ATOMS);
            tol_sel = $urandom_range(0, 9);
            if (tol_sel == 0) next_tol = TOL_MAX;
            else if (tol_sel == 1) next_tol = $urandom_range(1, 255);
            else if (tol_sel < 4) next_tol = int'(TOL_RESET);
            else next_tol = $urandom_range(256, 65535);
            set_config(next_count, next_tol);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_item();
                // occasional full drain in mid phase
                if ($urandom_range(0, 63) == 0) settle(0);
            end
        end

        // room for a full sweep in case a stray result is still coming
        settle(ATOMS + 16);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* symmetry_image_atom_finder_core.f */
rtl/siaf_pkg.sv
rtl/siaf_in_if.sv
rtl/siaf_out_if.sv
rtl/siaf_ctrl.sv
rtl/siaf_datapath.sv
rtl/symmetry_image_atom_finder_core.sv
verif/siaf_match_checker.sv
verif/tb_symmetry_image_atom_finder_core.sv
